[rtl/strm_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse table range minimum: shared package
// Field widths, request and result structs, mode and status codes, the
// control structs between the top level and the core, and helper functions.
// ----------------------------------------------------------------------------
package strm_pkg;

  // Default sizes of the table and the stored values.
  localparam int DEF_MAX_LENGTH = 1024;
  localparam int DEF_LEVELS     = 11;
  localparam int DEF_VALUE_BITS = 20;

  // Fixed field widths of the request and result items.
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 20;
  localparam int TOTAL_W = 48;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 11;

  // A range length spans one bit more than an index; its log fits in K_W bits.
  localparam int LEN_W = INDEX_W + 1;
  localparam int K_W   = $clog2(LEN_W);

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] elem_index;
    logic [VALUE_W-1:0] elem_value;
    logic [INDEX_W-1:0] range_left;
    logic [INDEX_W-1:0] range_right;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] range_min;
    logic [TOTAL_W-1:0] running_total;
    logic [STAT_W-1:0]  status;
  } out_t;

  // Control from the top level to the core.
  typedef struct packed {
    logic start;
    logic cfg_write;
    logic out_free;
  } core_ctl_t;

  // Status from the core to the top level.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_sts_t;

  // Position of the highest set bit; zero for an input of zero.
  function automatic logic [K_W-1:0] floor_log2(input logic [LEN_W-1:0] v);
    logic [K_W-1:0] r;
    r = '0;
    for (int b = 0; b < LEN_W; b++) begin
      if (v[b]) begin
        r = K_W'(b);
      end
    end
    return r;
  endfunction

endpackage

[rtl/strm_mem.sv]
// ----------------------------------------------------------------------------
// Sparse table range minimum: table memory
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module strm_mem #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 20
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data available in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/strm_core.sv]
// ----------------------------------------------------------------------------
// Sparse table range minimum: sequencer core
// Runs loads, table builds and queries one request at a time through the
// table memory and a single shared minimum unit, and keeps the running total.
// ----------------------------------------------------------------------------
module strm_core #(
  parameter int MAX_LENGTH = strm_pkg::DEF_MAX_LENGTH,
  parameter int LEVELS     = strm_pkg::DEF_LEVELS,
  parameter int VALUE_BITS = strm_pkg::DEF_VALUE_BITS,
  parameter int NW         = $clog2(MAX_LENGTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  strm_pkg::core_ctl_t ctl,
  input  strm_pkg::in_t      req,
  input  logic [NW-1:0]      len_eff,
  output strm_pkg::core_sts_t sts,
  output strm_pkg::out_t     res
);

  import strm_pkg::*;

  localparam int AW   = $clog2(MAX_LENGTH);
  localparam int LVW  = $clog2(LEVELS);
  localparam int LCW  = $clog2(LEVELS + 1);
  localparam int ADW  = LVW + AW;
  localparam int SW   = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_BLD_LVL, S_BLD_A, S_BLD_B, S_BLD_W,
    S_Q_A, S_Q_B, S_Q_M, S_REPLY
  } state_t;

  state_t state;

  // Request and working registers.
  in_t                   cur;
  logic                  built;
  logic [TOTAL_W-1:0]    total;
  logic [VALUE_W-1:0]    res_min;
  logic [STAT_W-1:0]     res_status;
  logic [LCW-1:0]        lvl;
  logic [SW-1:0]         span;
  logic [NW-1:0]         ent;
  logic [LVW-1:0]        k;
  logic [AW-1:0]         second;
  logic [VALUE_BITS-1:0] first_val;

  // Memory port signals.
  logic                  wr_en;
  logic [ADW-1:0]        wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic [ADW-1:0]        rd_addr;
  logic [VALUE_BITS-1:0] rd_data;

  // Shared minimum unit and query helpers.
  logic [VALUE_BITS-1:0] mn;
  logic [LEN_W-1:0]      q_len;
  logic [K_W-1:0]        q_log;
  logic [LEN_W-1:0]      q_second;
  logic [SW-1:0]         ent_end;
  logic [LVW-1:0]        lvl_prev;
  logic                  load_ok;

  assign mn       = (first_val < rd_data) ? first_val : rd_data;
  assign q_len    = {1'b0, cur.range_right} - {1'b0, cur.range_left} + LEN_W'(1);
  assign q_log    = floor_log2(q_len);
  assign q_second = {1'b0, cur.range_right} + LEN_W'(1) - (LEN_W'(1) << k);
  assign ent_end  = SW'(ent) + span;
  assign lvl_prev = LVW'(lvl - LCW'(1));
  assign load_ok  = (cur.elem_index < MAX_LENGTH);

  strm_mem #(
    .ADDR_W(ADW),
    .DATA_W(VALUE_BITS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Memory write: element loads and built table entries.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {LVW'(0), AW'(cur.elem_index)};
    wr_data = VALUE_BITS'(cur.elem_value);
    if (state == S_DECODE && cur.mode == MODE_LOAD && load_ok) begin
      wr_en = 1'b1;
    end else if (state == S_BLD_W) begin
      wr_en   = 1'b1;
      wr_addr = {LVW'(lvl), AW'(ent)};
      wr_data = mn;
    end
  end

  // Memory read address for each step.
  always_comb begin
    case (state)
      S_BLD_A: rd_addr = {lvl_prev, AW'(ent)};
      S_BLD_B: rd_addr = {lvl_prev, AW'(SW'(ent) + (span >> 1))};
      S_Q_A:   rd_addr = {k, AW'(cur.range_left)};
      S_Q_B:   rd_addr = {k, second};
      default: rd_addr = {lvl_prev, AW'(ent)};
    endcase
  end

  assign sts.idle      = (state == S_IDLE);
  assign sts.res_valid = (state == S_REPLY) && ctl.out_free;

  assign res.range_min     = res_min;
  assign res.running_total = total;
  assign res.status        = res_status;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      built <= 1'b0;
      total <= '0;
    end else begin
      if (ctl.cfg_write) begin
        built <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            cur   <= req;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_min    <= '0;
          res_status <= ST_OK;
          state      <= S_REPLY;
          case (cur.mode)
            MODE_LOAD: begin
              built <= 1'b0;
            end
            MODE_BUILD: begin
              lvl   <= LCW'(1);
              span  <= SW'(2);
              state <= S_BLD_LVL;
            end
            MODE_QUERY: begin
              if (!built) begin
                res_status <= ST_NOT_BUILT;
              end else if (cur.range_left > cur.range_right || cur.range_right >= len_eff) begin
                res_status <= ST_BAD_RANGE;
              end else begin
                if (q_log > LEVELS - 1) begin
                  k <= LVW'(LEVELS - 1);
                end else begin
                  k <= LVW'(q_log);
                end
                state <= S_Q_A;
              end
            end
            default: begin
            end
          endcase
        end
        // Start a level, or finish when no further level fits.
        S_BLD_LVL: begin
          ent <= '0;
          if (lvl < LEVELS && span <= SW'(len_eff)) begin
            state <= S_BLD_A;
          end else begin
            built <= 1'b1;
            state <= S_REPLY;
          end
        end
        S_BLD_A: begin
          if (ent_end <= SW'(len_eff)) begin
            state <= S_BLD_B;
          end else begin
            lvl   <= lvl + LCW'(1);
            span  <= span << 1;
            state <= S_BLD_LVL;
          end
        end
        S_BLD_B: begin
          first_val <= rd_data;
          state     <= S_BLD_W;
        end
        S_BLD_W: begin
          ent   <= ent + NW'(1);
          state <= S_BLD_A;
        end
        // Query: read both overlapping blocks, then combine.
        S_Q_A: begin
          second <= AW'(q_second);
          state  <= S_Q_B;
        end
        S_Q_B: begin
          first_val <= rd_data;
          state     <= S_Q_M;
        end
        S_Q_M: begin
          res_min <= VALUE_W'(mn);
          total   <= total + TOTAL_W'(mn);
          state   <= S_REPLY;
        end
        S_REPLY: begin
          if (ctl.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/sparse_table_range_minimum.sv]
// ----------------------------------------------------------------------------
// Sparse table range minimum: top level
// Range-minimum engine over a stored array with a sparse table and a running
// total of query minima.
// ----------------------------------------------------------------------------
// Usage:
// A request on in_data (valid/ready) is a load (mode 0), a build (mode 1) or
// a query (mode 2). Every request gives exactly one result on out_data
// (valid/ready) with range_min, running_total and status.
// The length register is written on cfg_data (valid/ready, always ready) and
// must only be written while no request is in flight; a write forces a
// rebuild.
// One request is processed at a time; in_ready is low until it finishes.
// Steps from acceptance to the result register: loads and other modes pass
// the decode step and the reply; queries also take two reads of the single
// table read port plus one compare. The next request is accepted only once
// the result has gone into the output register. A build reads two entries
// and writes one per table entry.
// A finished result waits in the output register; the next request is still
// accepted, but its result is held in the core until the receiver takes the
// previous one.
// Reset clears the total, the built mark and the result valid flag, and sets
// the length to 1. The table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sparse_table_range_minimum #(
  parameter int MAX_LENGTH = strm_pkg::DEF_MAX_LENGTH,
  parameter int LEVELS     = strm_pkg::DEF_LEVELS,
  parameter int VALUE_BITS = strm_pkg::DEF_VALUE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  strm_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output strm_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [strm_pkg::CFG_W-1:0] cfg_data
);

  import strm_pkg::*;

  localparam int NW = $clog2(MAX_LENGTH + 1);

  logic [NW-1:0] len_eff;
  core_ctl_t     ctl;
  core_sts_t     sts;
  out_t          core_res;
  logic          cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_ready  = sts.idle;

  assign ctl.start     = in_valid && in_ready;
  assign ctl.cfg_write = cfg_write;
  assign ctl.out_free  = !out_valid || out_ready;

  // Length register, clamped into 1 .. MAX_LENGTH on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_eff <= NW'(1);
    end else if (cfg_write) begin
      if (cfg_data == '0) begin
        len_eff <= NW'(1);
      end else if (cfg_data > MAX_LENGTH) begin
        len_eff <= NW'(MAX_LENGTH);
      end else begin
        len_eff <= NW'(cfg_data);
      end
    end
  end

  strm_core #(
    .MAX_LENGTH(MAX_LENGTH),
    .LEVELS    (LEVELS),
    .VALUE_BITS(VALUE_BITS),
    .NW        (NW)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req    (in_data),
    .len_eff(len_eff),
    .sts    (sts),
    .res    (core_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.res_valid) begin
      out_data <= core_res;
    end
  end

  // The core only hands over a result when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    sts.res_valid |-> (!out_valid || out_ready))
    else $error("result handed over while output register is full");

  // An accepted request leaves the block busy in the cycle after.
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still starting");

  // Failed requests never report a minimum.
  a_error_zero_min: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> (out_data.range_min == '0))
    else $error("error result carries a nonzero minimum");

endmodule
